// ----- rtl/tmwf_pkg.sv -----
// Shared types and constants for the trimmed-mean window filter.
// No dependencies; imported by tmwf_div, trimmed_mean_window_filter and tb_top.
package tmwf_pkg;

  localparam int unsigned CH_W     = 4;   // channel field
  localparam int unsigned SAMPLE_W = 16;  // sample, extremes and average
  localparam int unsigned SUM_W    = 22;  // running sum of up to 63 samples
  localparam int unsigned CNT_W    = 6;   // valid count and refresh position
  localparam int unsigned NUM_W    = 24;  // sum - max - min, signed

  localparam logic signed [SAMPLE_W-1:0] FLOOR_RESET  = -16'sd163;
  localparam logic signed [SAMPLE_W-1:0] MIN_START    = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] AVG_MAX      = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] AVG_MIN      = -16'sd32768;
  localparam logic [CNT_W-1:0]           WINDOW_RESET = 6'd10;
  localparam logic [CNT_W-1:0]           TRIM_COUNT   = 6'd2;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_VALID_FLOOR = 1'b0,
    REG_WINDOW_LEN  = 1'b1
  } cfg_reg_e;

  // One channel's window
  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] max;
    logic signed [SAMPLE_W-1:0] min;
    logic [CNT_W-1:0]           cnt;
    logic [CNT_W-1:0]           pos;
  } win_entry_t;

  // Divide request toward the shared divider
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;  // magnitude
    logic [CNT_W-1:0] divisor;   // nonzero whenever start is set
  } div_req_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/tmwf_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tmwf_pkg for widths and the request/response structs.
module tmwf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmwf_pkg::div_req_t req_i,
  output tmwf_pkg::div_rsp_t rsp_o
);
  import tmwf_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [CNT_W:0]      rem_q, rem_d;
  logic [NUM_W-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0]    den_q, den_d;
  logic [CNT_W:0]      rem_shift;
  logic                fits;

  // Shift in the next dividend bit and try a subtract
  assign rem_shift = {rem_q[CNT_W-1:0], quo_q[NUM_W-1]};
  assign fits      = rem_shift >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (busy_q) begin
      rem_d  = fits ? (rem_shift - {1'b0, den_q}) : rem_shift;
      quo_d  = {quo_q[NUM_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(NUM_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath holds no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- rtl/trimmed_mean_window_filter.sv -----
// Top level of the trimmed-mean window filter: per-channel window memory,
// sequencer and output register. Depends on tmwf_pkg and tmwf_div.
//
// Each transfer on the input stream is one refresh of one channel (tuser) with
// its signed sample (tdata). Samples at or above valid_floor are folded into
// the channel's sum, maximum, minimum and count until window_len refreshes
// have passed; the next refresh of that channel ends the window, and if more
// than two samples were valid the block emits (sum - max - min) / (count - 2),
// truncated toward zero and saturated to 16 bits, then restarts the window.
// Channels at or above CHANNELS are dropped. The block handles one item at a
// time: a refresh that only folds or restarts passes through accept, window
// memory read and write back; one that emits an average passes through accept,
// read, write back and divider start, the divide steps of the shared divider,
// sign and saturate, and the load of the output register, plus any wait for
// the output register to drain. Per-channel valid bits make every window start
// out clean after reset, so no clearing pass is needed. Write configuration
// only while the block is idle.
module trimmed_mean_window_filter #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tmwf_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
  input  logic [tmwf_pkg::CH_W-1:0]     s_axis_tuser,   // [3:0] channel
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tmwf_pkg::SAMPLE_W-1:0] m_axis_tdata,   // [15:0] average
  output logic [tmwf_pkg::CH_W-1:0]     m_axis_tuser,   // [3:0] out_channel
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  tmwf_pkg::cfg_reg_e            cfg_index_i,
  input  logic [tmwf_pkg::SAMPLE_W-1:0] cfg_data_i
);
  import tmwf_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned EXT_W = IDX_W + CH_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV,
    S_EMIT
  } state_e;

  state_e                     state_q, state_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [CH_W-1:0]            ch_q, ch_d;
  logic signed [SAMPLE_W-1:0] smp_q, smp_d;
  logic                       neg_q, neg_d;
  logic signed [SAMPLE_W-1:0] avg_q, avg_d;
  logic                       ovld_q, ovld_d;
  logic [SAMPLE_W-1:0]        odata_q, odata_d;
  logic [CH_W-1:0]            och_q, och_d;
  logic [CHANNELS-1:0]        vld_q, vld_d;

  logic signed [SAMPLE_W-1:0] floor_q;
  logic [CNT_W-1:0]           wlen_q;

  win_entry_t                 mem [CHANNELS];
  win_entry_t                 rd_q;
  win_entry_t                 cur;
  win_entry_t                 wr_entry;
  logic                       wr_en;

  logic [EXT_W-1:0]           ch_ext;
  logic                       ch_ok;
  logic                       in_xfer;
  logic signed [NUM_W-1:0]    num;
  logic [CNT_W-1:0]           den;
  logic [NUM_W-1:0]           qmag;

  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = och_q;

  // Range check and memory index of the incoming channel
  assign ch_ext = EXT_W'(s_axis_tuser);
  assign ch_ok  = ch_ext < EXT_W'(CHANNELS);

  // Window as read, or a fresh one for a channel never written
  always_comb begin
    if (vld_q[idx_q]) begin
      cur = rd_q;
    end else begin
      cur.sum = '0;
      cur.max = FLOOR_RESET;
      cur.min = MIN_START;
      cur.cnt = '0;
      cur.pos = '0;
    end
  end

  // Trimmed numerator and divisor of the closing window
  assign num = NUM_W'(cur.sum) - NUM_W'(cur.max) - NUM_W'(cur.min);
  assign den = cur.cnt - TRIM_COUNT;

  assign div_req.start    = (state_q == S_UPDATE) && (cur.pos >= wlen_q)
                            && (cur.cnt > TRIM_COUNT);
  assign div_req.dividend = num[NUM_W-1] ? (-num) : num;
  assign div_req.divisor  = den;

  tmwf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign qmag = div_rsp.quotient;

  // Next window: restart at the end position, else advance and fold a valid sample
  always_comb begin
    wr_entry = cur;
    wr_en    = (state_q == S_UPDATE);
    if (cur.pos >= wlen_q) begin
      wr_entry.sum = '0;
      wr_entry.max = floor_q;
      wr_entry.min = MIN_START;
      wr_entry.cnt = '0;
      wr_entry.pos = '0;
    end else begin
      if (smp_q >= floor_q) begin
        if (smp_q > cur.max) wr_entry.max = smp_q;
        if (smp_q < cur.min) wr_entry.min = smp_q;
        wr_entry.cnt = cur.cnt + CNT_W'(1);
        wr_entry.sum = cur.sum + SUM_W'(smp_q);
      end
      wr_entry.pos = cur.pos + CNT_W'(1);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    ch_d    = ch_q;
    smp_d   = smp_q;
    neg_d   = neg_q;
    avg_d   = avg_q;
    ovld_d  = ovld_q && !m_axis_tready;
    odata_d = odata_q;
    och_d   = och_q;
    vld_d   = vld_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && ch_ok) begin
          idx_d   = ch_ext[IDX_W-1:0];
          ch_d    = s_axis_tuser;
          smp_d   = s_axis_tdata;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        vld_d[idx_q] = 1'b1;
        neg_d        = num[NUM_W-1];
        state_d      = div_req.start ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          // Apply sign and saturate to 16 bits
          if (neg_q) begin
            avg_d = (qmag > NUM_W'(32768)) ? AVG_MIN : SAMPLE_W'(-qmag);
          end else begin
            avg_d = (qmag > NUM_W'(32767)) ? AVG_MAX : SAMPLE_W'(qmag);
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d  = 1'b1;
          odata_d = avg_q;
          och_d   = ch_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      vld_q   <= '0;
      floor_q <= FLOOR_RESET;
      wlen_q  <= WINDOW_RESET;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      vld_q   <= vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_VALID_FLOOR: floor_q <= cfg_data_i;
          REG_WINDOW_LEN:  wlen_q  <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers hold no reset
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    ch_q    <= ch_d;
    smp_q   <= smp_d;
    neg_q   <= neg_d;
    avg_q   <= avg_d;
    odata_q <= odata_d;
    och_q   <= och_d;
  end

  // Window memory: at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q] <= wr_entry;
    end
    rd_q <= mem[idx_q];
  end

`ifndef SYNTHESIS
  // Divider works only while a closing window waits on it
  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  // Never start a divide by zero
  a_div_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divide started with zero divisor");

  // A new result appears only from the emit step
  a_emit_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && !$past(ovld_q)) |-> ($past(state_q) == S_EMIT))
    else $error("output loaded outside emit step");

  // Inputs are taken only while no item is in flight
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !div_rsp.busy && !div_rsp.done)
    else $error("input accepted during a divide");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for trimmed_mean_window_filter: directed table, then random phases.
// Each phase sets the floor and window length; a predictor checks every average.
// Depends on tmwf_pkg and the filter RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmwf_pkg::*;

  localparam int NUM_CH        = 16;
  localparam int SETTLE_CYCLES = 40;

  typedef enum logic {
    ROW_REFRESH,
    ROW_WRITE
  } row_kind_e;

  // One row of the directed table; typed_avg is used only where has_typed is set
  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    reg_sel;
    logic [3:0]  chan;
    logic [15:0] value;
    logic        has_typed;
    logic [15:0] typed_avg;
  } dir_row_t;

  typedef struct packed {
    logic [3:0]  chan;
    logic [15:0] avg;
  } mean_result_t;

  // Predicted window of one channel
  typedef struct {
    int sum;
    int hi;
    int lo;
    int cnt;
    int pos;
  } chan_win_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index_i = REG_VALID_FLOOR;
  logic [15:0] cfg_data_i = '0;

  logic signed [15:0] floor_cfg;
  logic [5:0]         wlen_cfg;
  chan_win_t          win_tab [NUM_CH];
  mean_result_t       mean_q [$];
  int                 mismatch_cnt = 0;
  bit                 steady = 1'b0;

  // Directed part: short windows, extremes, stale maximum with saturation,
  // shrinking window length and a zero window length
  dir_row_t dir_rows [27] = '{
    '{ROW_WRITE,   REG_WINDOW_LEN,  4'd0,  16'd3,         1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd0,  16'd32767,     1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd0,  -16'sd163,     1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd0,  16'd100,       1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd0,  -16'sd1,       1'b1, 16'd100},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd15, 16'h8000,      1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd15, -16'sd164,     1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd15, 16'd5,         1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd15, 16'd0,         1'b0, 16'd0},
    '{ROW_WRITE,   REG_VALID_FLOOR, 4'd0,  16'd32767,     1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd1,  16'd0,         1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd1,  16'd0,         1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd1,  16'd0,         1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd1,  16'd0,         1'b0, 16'd0},
    '{ROW_WRITE,   REG_VALID_FLOOR, 4'd0,  16'h8000,      1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd1,  16'h8000,      1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd1,  16'h8000,      1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd1,  16'h8000,      1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd1,  16'h8000,      1'b1, 16'h8000},
    '{ROW_WRITE,   REG_WINDOW_LEN,  4'd0,  16'd63,        1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd5,  16'd1000,      1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd5,  -16'sd2000,    1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd5,  16'd30,        1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd5,  16'd31,        1'b0, 16'd0},
    '{ROW_WRITE,   REG_WINDOW_LEN,  4'd0,  16'd0,         1'b0, 16'd0},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd5,  16'h8000,      1'b1, 16'd30},
    '{ROW_REFRESH, REG_VALID_FLOOR, 4'd6,  -16'sd9,       1'b0, 16'd0}
  };

  trimmed_mean_window_filter #(
    .CHANNELS(NUM_CH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Restart one channel's window at the current floor
  function automatic void restart_window(input int ch);
    win_tab[ch].sum = 0;
    win_tab[ch].hi  = floor_cfg;
    win_tab[ch].lo  = MIN_START;
    win_tab[ch].cnt = 0;
    win_tab[ch].pos = 0;
  endfunction

  // Advance one channel by one refresh; return 1 when an average is due
  function automatic bit predict_refresh(input logic [3:0] ch, input logic signed [15:0] smp,
                                         output logic [15:0] avg);
    int num;
    int q;
    bit got;
    got = 1'b0;
    avg = '0;
    if (int'(ch) >= NUM_CH) return 1'b0;
    if (win_tab[ch].pos >= int'(wlen_cfg)) begin
      if (win_tab[ch].cnt > 2) begin
        num = win_tab[ch].sum - win_tab[ch].hi - win_tab[ch].lo;
        q = num / (win_tab[ch].cnt - 2);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        avg = q[15:0];
        got = 1'b1;
      end
      restart_window(ch);
    end else begin
      // fold only samples at or above the floor
      if (smp >= floor_cfg) begin
        if (int'(smp) > win_tab[ch].hi) win_tab[ch].hi = smp;
        if (int'(smp) < win_tab[ch].lo) win_tab[ch].lo = smp;
        win_tab[ch].cnt = (win_tab[ch].cnt + 1) & 63;
        win_tab[ch].sum = win_tab[ch].sum + int'(smp);
      end
      win_tab[ch].pos = (win_tab[ch].pos + 1) & 63;
    end
    return got;
  endfunction

  // Samples biased toward the extremes and the floor
  function automatic logic [15:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0: v = -32768;
      1: v = 32767;
      2, 3: v = int'(floor_cfg) + int'($urandom_range(6)) - 3;
      4, 5: v = int'(floor_cfg) + int'($urandom_range(2000));
      default: v = int'($urandom_range(65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Present one refresh and hold it until the transfer completes
  task automatic push_refresh(input logic [3:0] ch, input logic [15:0] smp);
    cfg_valid_i <= 1'b0;
    if (!steady && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (!steady && $urandom_range(99) < 26);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ch;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Write one register; valid is left high so back-to-back writes need no gap
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_VALID_FLOOR: floor_cfg = data;
      REG_WINDOW_LEN:  wlen_cfg = data[5:0];
      default: ;
    endcase
  endtask

  // Hold off until every average has arrived and the last refresh is done
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) m_axis_tready <= steady || ($urandom_range(99) >= 26);

  // Compare each output transfer with the oldest predicted average
  always @(posedge clk_i) begin : check_out
    mean_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mean_q.size() == 0) begin
        $display("%0t: unexpected average: expected none, actual chan %0d avg %0d",
                 $realtime, m_axis_tuser, $signed(m_axis_tdata));
        mismatch_cnt++;
      end else begin
        want = mean_q.pop_front();
        if (m_axis_tuser !== want.chan) begin
          $display("%0t: channel mismatch: expected %0d, actual %0d",
                   $realtime, want.chan, m_axis_tuser);
          mismatch_cnt++;
        end
        if (m_axis_tdata !== want.avg) begin
          $display("%0t: average mismatch on chan %0d: expected %0d, actual %0d",
                   $realtime, want.chan, $signed(want.avg), $signed(m_axis_tdata));
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stim
    logic [15:0] avg;
    logic [3:0]  ch;
    logic [15:0] smp;
    logic [15:0] floor_val;
    int          wlen_val;
    int          ch_hi;
    int          n_items;
    bit          last_write;

    floor_cfg = FLOOR_RESET;
    wlen_cfg  = WINDOW_RESET;
    for (int c = 0; c < NUM_CH; c++) restart_window(c);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    last_write = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (!last_write) wait_idle();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
        last_write = 1'b1;
      end else begin
        push_refresh(dir_rows[i].chan, dir_rows[i].value);
        last_write = 1'b0;
        if (predict_refresh(dir_rows[i].chan, dir_rows[i].value, avg)) begin
          if (dir_rows[i].has_typed) mean_q.push_back('{dir_rows[i].chan, dir_rows[i].typed_avg});
          else mean_q.push_back('{dir_rows[i].chan, avg});
        end
      end
    end

    // Random phases; windows carry over, so shrinking and stale maxima occur
    for (int p = 0; p < 11; p++) begin
      wait_idle();
      floor_val = $urandom_range(65535);
      ch_hi     = 7;
      steady    = 1'b0;
      case (p)
        0: begin
          floor_val = FLOOR_RESET; wlen_val = 10; ch_hi = 15; n_items = 300; steady = 1'b1;
        end
        1: begin
          floor_val = 16'd0; wlen_val = 3; ch_hi = 15; n_items = 200;
        end
        2: begin
          floor_val = 16'h8000; wlen_val = 63; ch_hi = 3; n_items = 260;
        end
        3: begin
          floor_val = 16'd32767; wlen_val = 5; ch_hi = 15; n_items = 100;
        end
        4: begin
          wlen_val = 2; n_items = 60;
        end
        5: begin
          wlen_val = 1; n_items = 40;
        end
        6: begin
          wlen_val = 0; n_items = 40;
        end
        default: begin
          wlen_val = $urandom_range(63, 3); ch_hi = $urandom_range(15); n_items = 160;
        end
      endcase
      write_reg(REG_VALID_FLOOR, floor_val);
      // upper data bits are don't-care for the window length
      write_reg(REG_WINDOW_LEN, {10'($urandom_range(1023)), 6'(wlen_val)});
      for (int k = 0; k < n_items; k++) begin
        ch  = $urandom_range(ch_hi);
        smp = pick_sample();
        push_refresh(ch, smp);
        if (predict_refresh(ch, smp, avg)) mean_q.push_back('{ch, avg});
      end
    end

    steady = 1'b0;
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- trimmed_mean_window_filter.f -----
rtl/tmwf_pkg.sv
rtl/tmwf_div.sv
rtl/trimmed_mean_window_filter.sv
tb/tb_top.sv
